// File: rtl/core/vstc_pkg.sv
// shared types and constants of the transition controller
// no dependencies
package vstc_pkg;

  localparam int KEYER_COUNT = 4;
  localparam int LANES       = 4;
  localparam int KI_W        = (KEYER_COUNT > 1) ? $clog2(KEYER_COUNT) : 1;
  localparam int QB          = 15;

  localparam logic [15:0] FULL = 16'h8000;
  localparam logic [15:0] HALF = 16'h4000;

  // request to the shared divider: quotient of num * 2^15 / den
  typedef struct packed {
    logic        start;
    logic        ceil;
    logic [32:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_res_t;

endpackage

// File: rtl/core/video_switcher_transition_control.sv
// top level of the mix/effects transition controller
// depends on vstc_pkg and vstc_div
//
// Commands other than tick are handled in idle and give no output transaction.
// A tick runs a sequence through one shared divider: fade ramp, one ramp per
// keyer that is not riding, auto progress, then a multiply (ST_MUL) and an
// update (ST_RIDE) per riding keyer on one multiplier. Ramps are skipped when
// no ticks elapsed. A tick also waits for any snapshot still held in the output
// register; in_stall is high for that time. The finished snapshot sits in an
// output register, so a new command is taken while it waits.
module video_switcher_transition_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic [31:0] in_now_tick,
  input  logic [7:0]  in_source,
  input  logic [15:0] in_tbar_position,
  input  logic [2:0]  in_keyer_index,
  input  logic        in_tie_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_program_source,
  output logic [7:0]  out_preview_source,
  output logic [15:0] out_mix_alpha,
  output logic [2:0]  out_style_out,
  output logic [15:0] out_softness_out,
  output logic [15:0] out_fade_level,
  output logic        out_transition_active,
  output logic [63:0] out_keyer_levels,
  output logic [3:0]  out_keyer_on_mask,
  output logic [3:0]  out_keyer_tie_mask,
  output logic [31:0] out_keyer_sources_out,
  output logic [3:0]  out_keyer_follow_out
);

  localparam int KC = vstc_pkg::KEYER_COUNT;
  localparam int KW = vstc_pkg::KI_W;

  // command codes
  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_PROGRAM  = 4'd1;
  localparam logic [3:0] CMD_PREVIEW  = 4'd2;
  localparam logic [3:0] CMD_CUT      = 4'd3;
  localparam logic [3:0] CMD_AUTO     = 4'd4;
  localparam logic [3:0] CMD_TBAR_BEG = 4'd5;
  localparam logic [3:0] CMD_TBAR_MOV = 4'd6;
  localparam logic [3:0] CMD_FADE     = 4'd7;
  localparam logic [3:0] CMD_KEY_TOG  = 4'd8;
  localparam logic [3:0] CMD_KEY_TIE  = 4'd9;

  // register indexes
  localparam logic [2:0] REG_TRANS_DUR = 3'd0;
  localparam logic [2:0] REG_STYLE     = 3'd1;
  localparam logic [2:0] REG_SOFTNESS  = 3'd2;
  localparam logic [2:0] REG_FADE_DUR  = 3'd3;
  localparam logic [2:0] REG_KEY_DUR   = 3'd4;
  localparam logic [2:0] REG_KEY_SRC   = 3'd5;
  localparam logic [2:0] REG_KEY_FOL   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FADE_DIV, ST_FADE_WAIT, ST_KEY_DIV, ST_KEY_WAIT,
    ST_AUTO_DIV, ST_AUTO_WAIT, ST_MUL, ST_RIDE, ST_OUT
  } state_t;

  // configuration
  logic [31:0] trans_dur_r;
  logic [2:0]  style_r;
  logic [15:0] softness_r;
  logic [31:0] fade_dur_r;
  logic [63:0] key_dur_r;
  logic [31:0] key_src_r;
  logic [3:0]  key_fol_r;

  // switcher state
  state_t      state_r;
  logic [7:0]  program_r;
  logic [7:0]  preview_r;
  logic        auto_run_r;
  logic        tbar_held_r;
  logic [31:0] auto_start_r;
  logic [15:0] tbar_level_r;
  logic [15:0] fade_r;
  logic        fade_goal_r;
  logic [31:0] prev_tick_r;
  logic        prev_valid_r;
  logic [15:0] key_level_r [KC];
  logic [15:0] key_origin_r [KC];
  logic [KC-1:0] key_goal_r;
  logic [KC-1:0] key_tied_r;
  logic [KC-1:0] key_riding_r;

  // tick working registers
  logic [31:0] now_r;
  logic [31:0] elapsed_r;
  logic [15:0] alpha_r;
  logic [KW-1:0] key_cnt_r;
  logic [31:0] prod_r;

  // output register
  logic        out_valid_r;
  logic [7:0]  o_prog_r;
  logic [7:0]  o_prev_r;
  logic [15:0] o_alpha_r;
  logic [2:0]  o_style_r;
  logic [15:0] o_soft_r;
  logic [15:0] o_fade_r;
  logic        o_active_r;
  logic [63:0] o_levels_r;
  logic [3:0]  o_on_r;
  logic [3:0]  o_tie_r;
  logic [31:0] o_src_r;
  logic [3:0]  o_fol_r;

  vstc_pkg::div_req_t div_req;
  vstc_pkg::div_res_t div_res;

  vstc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  function automatic logic [15:0] ramp_to(input logic [15:0] lvl, input logic goal,
                                          input logic [15:0] step);
    logic [15:0] tgt;
    logic [15:0] res;
    tgt = goal ? vstc_pkg::FULL : 16'd0;
    res = lvl;
    if (lvl < tgt) begin
      res = ((tgt - lvl) <= step) ? tgt : lvl + step;
    end else if (lvl > tgt) begin
      res = ((lvl - tgt) <= step) ? tgt : lvl - step;
    end
    return res;
  endfunction

  logic        in_acc;
  logic        out_acc;
  logic        active;
  logic [KW-1:0] ki;
  logic        ki_ok;
  logic [31:0] elapsed_in;
  logic [15:0] key_dur_k;
  logic [32:0] auto_n;
  logic        key_last;

  // next values of the keyer group for complete, cancel and arm
  logic [15:0] cmp_level [KC];
  logic [KC-1:0] cmp_goal;
  logic [KC-1:0] cnl_goal;
  logic [KC-1:0] arm_goal;
  logic        was_active;

  logic [63:0] lvl_pack;
  logic [3:0]  on_pack;
  logic [3:0]  tie_pack;
  logic [31:0] src_pack;
  logic [3:0]  fol_pack;

  always_comb begin
    in_acc     = in_valid && !in_stall;
    out_acc    = out_valid_r && !out_stall;
    active     = auto_run_r || tbar_held_r;
    was_active = active;
    ki         = in_keyer_index[KW-1:0];
    ki_ok      = {1'b0, in_keyer_index} < 4'(KC);
    elapsed_in = (prev_valid_r && (in_now_tick > prev_tick_r)) ?
                 in_now_tick - prev_tick_r : 32'd0;
    key_dur_k  = key_dur_r[16*key_cnt_r +: 16];
    auto_n     = {1'b0, now_r - auto_start_r} + 33'd1;
    key_last   = key_cnt_r == KW'(KC - 1);
    for (int k = 0; k < KC; k++) begin
      cmp_goal[k]  = key_goal_r[k];
      cmp_level[k] = key_level_r[k];
      if (key_riding_r[k]) begin
        cmp_level[k] = key_goal_r[k] ? vstc_pkg::FULL : 16'd0;
      end else if (key_tied_r[k] && !was_active) begin
        cmp_goal[k]  = !key_goal_r[k];
        cmp_level[k] = !key_goal_r[k] ? vstc_pkg::FULL : 16'd0;
      end
      cnl_goal[k] = key_riding_r[k] ? (key_origin_r[k] > vstc_pkg::HALF) : key_goal_r[k];
      arm_goal[k] = key_tied_r[k] ? !key_goal_r[k] : key_goal_r[k];
    end
    lvl_pack = '0;
    on_pack  = '0;
    tie_pack = '0;
    src_pack = '0;
    fol_pack = '0;
    for (int k = 0; k < vstc_pkg::LANES; k++) begin
      if (k < KC) begin
        lvl_pack[16*k +: 16] = key_level_r[k];
        on_pack[k]           = key_goal_r[k];
        tie_pack[k]          = key_tied_r[k];
        src_pack[8*k +: 8]   = key_src_r[8*k +: 8];
        fol_pack[k]          = key_fol_r[k];
      end
    end
  end

  // divider requests from the sequencer
  always_comb begin
    div_req.start = 1'b0;
    div_req.ceil  = 1'b1;
    div_req.num   = {1'b0, elapsed_r};
    div_req.den   = (fade_dur_r == 32'd0) ? 32'd1 : fade_dur_r;
    unique case (state_r)
      ST_FADE_DIV: begin
        div_req.start = elapsed_r != 32'd0;
      end
      ST_KEY_DIV: begin
        div_req.start = (elapsed_r != 32'd0) && !key_riding_r[key_cnt_r];
        div_req.den   = {16'd0, (key_dur_k == 16'd0) ? 16'd1 : key_dur_k};
      end
      ST_AUTO_DIV: begin
        div_req.start = auto_run_r && (now_r >= auto_start_r);
        div_req.ceil  = 1'b0;
        div_req.num   = auto_n;
        div_req.den   = (trans_dur_r == 32'd0) ? 32'd1 : trans_dur_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_dur_r  <= 32'd30;
      style_r      <= '0;
      softness_r   <= '0;
      fade_dur_r   <= 32'd30;
      key_dur_r    <= '0;
      key_src_r    <= '0;
      key_fol_r    <= '0;
      state_r      <= ST_IDLE;
      program_r    <= '0;
      preview_r    <= '0;
      auto_run_r   <= 1'b0;
      tbar_held_r  <= 1'b0;
      auto_start_r <= '0;
      tbar_level_r <= '0;
      fade_r       <= '0;
      fade_goal_r  <= 1'b0;
      prev_tick_r  <= '0;
      prev_valid_r <= 1'b0;
      key_goal_r   <= '0;
      key_tied_r   <= '0;
      key_riding_r <= '0;
      for (int k = 0; k < KC; k++) begin
        key_level_r[k]  <= '0;
        key_origin_r[k] <= '0;
      end
      key_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TRANS_DUR: trans_dur_r <= cfg_data[31:0];
          REG_STYLE:     style_r     <= cfg_data[2:0];
          REG_SOFTNESS:  softness_r  <= cfg_data[15:0];
          REG_FADE_DUR:  fade_dur_r  <= cfg_data[31:0];
          REG_KEY_DUR:   key_dur_r   <= cfg_data;
          REG_KEY_SRC:   key_src_r   <= cfg_data[31:0];
          REG_KEY_FOL:   key_fol_r   <= cfg_data[3:0];
          default: begin
          end
        endcase
      end

      // in ST_OUT the load below decides the flag
      if (out_acc && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_command)
              CMD_TICK: begin
                now_r        <= in_now_tick;
                elapsed_r    <= elapsed_in;
                prev_tick_r  <= in_now_tick;
                prev_valid_r <= 1'b1;
                state_r      <= ST_FADE_DIV;
              end
              CMD_PROGRAM, CMD_PREVIEW: begin
                // cancel: riding keyers fall back by origin
                key_goal_r   <= cnl_goal;
                key_riding_r <= '0;
                auto_run_r   <= 1'b0;
                tbar_held_r  <= 1'b0;
                tbar_level_r <= '0;
                if (in_command == CMD_PROGRAM) begin
                  program_r <= in_source;
                end else begin
                  preview_r <= in_source;
                end
              end
              CMD_CUT: begin
                program_r    <= preview_r;
                preview_r    <= program_r;
                key_goal_r   <= cmp_goal;
                key_riding_r <= '0;
                for (int k = 0; k < KC; k++) key_level_r[k] <= cmp_level[k];
                auto_run_r   <= 1'b0;
                tbar_held_r  <= 1'b0;
                tbar_level_r <= '0;
              end
              CMD_AUTO, CMD_TBAR_BEG: begin
                if (!active) begin
                  if (in_command == CMD_AUTO) begin
                    auto_run_r   <= 1'b1;
                    auto_start_r <= in_now_tick;
                  end else begin
                    tbar_held_r <= 1'b1;
                  end
                  key_riding_r <= key_riding_r | key_tied_r;
                  key_goal_r   <= arm_goal;
                  for (int k = 0; k < KC; k++) begin
                    if (key_tied_r[k]) key_origin_r[k] <= key_level_r[k];
                  end
                end
              end
              CMD_TBAR_MOV: begin
                if (tbar_held_r) begin
                  if (in_tbar_position >= vstc_pkg::FULL) begin
                    // bar at full lands the transition
                    program_r    <= preview_r;
                    preview_r    <= program_r;
                    key_goal_r   <= cmp_goal;
                    key_riding_r <= '0;
                    for (int k = 0; k < KC; k++) key_level_r[k] <= cmp_level[k];
                    auto_run_r   <= 1'b0;
                    tbar_held_r  <= 1'b0;
                    tbar_level_r <= '0;
                  end else begin
                    tbar_level_r <= in_tbar_position;
                  end
                end
              end
              CMD_FADE: begin
                fade_goal_r <= !fade_goal_r;
              end
              CMD_KEY_TOG: begin
                if (ki_ok) key_goal_r[ki] <= !key_goal_r[ki];
              end
              CMD_KEY_TIE: begin
                if (ki_ok) begin
                  key_tied_r[ki] <= in_tie_value;
                  if (!in_tie_value) key_riding_r[ki] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FADE_DIV: begin
          key_cnt_r <= '0;
          state_r   <= (elapsed_r != 32'd0) ? ST_FADE_WAIT : ST_KEY_DIV;
        end
        ST_FADE_WAIT: begin
          if (div_res.done) begin
            fade_r    <= ramp_to(fade_r, fade_goal_r, div_res.quo);
            key_cnt_r <= '0;
            state_r   <= ST_KEY_DIV;
          end
        end
        ST_KEY_DIV: begin
          if (div_req.start) begin
            state_r <= ST_KEY_WAIT;
          end else if (key_last) begin
            state_r <= ST_AUTO_DIV;
          end else begin
            key_cnt_r <= key_cnt_r + KW'(1);
          end
        end
        ST_KEY_WAIT: begin
          if (div_res.done) begin
            key_level_r[key_cnt_r] <= ramp_to(key_level_r[key_cnt_r],
                                              key_goal_r[key_cnt_r], div_res.quo);
            if (key_last) begin
              state_r <= ST_AUTO_DIV;
            end else begin
              key_cnt_r <= key_cnt_r + KW'(1);
              state_r   <= ST_KEY_DIV;
            end
          end
        end
        ST_AUTO_DIV: begin
          key_cnt_r <= '0;
          if (div_req.start) begin
            state_r <= ST_AUTO_WAIT;
          end else begin
            // auto before its start tick gives zero, held bar gives its level
            alpha_r <= (!auto_run_r && tbar_held_r) ? tbar_level_r : 16'd0;
            state_r <= ST_MUL;
          end
        end
        ST_AUTO_WAIT: begin
          if (div_res.done) begin
            if (div_res.quo == vstc_pkg::FULL) begin
              // auto landed on this tick
              alpha_r      <= '0;
              program_r    <= preview_r;
              preview_r    <= program_r;
              key_goal_r   <= cmp_goal;
              key_riding_r <= '0;
              for (int k = 0; k < KC; k++) key_level_r[k] <= cmp_level[k];
              auto_run_r   <= 1'b0;
              tbar_held_r  <= 1'b0;
              tbar_level_r <= '0;
            end else begin
              alpha_r <= div_res.quo;
            end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!active) begin
            state_r <= ST_OUT;
          end else if (key_riding_r[key_cnt_r]) begin
            prod_r  <= (key_goal_r[key_cnt_r] ?
                        vstc_pkg::FULL - key_origin_r[key_cnt_r] :
                        key_origin_r[key_cnt_r]) * alpha_r;
            state_r <= ST_RIDE;
          end else if (key_last) begin
            state_r <= ST_OUT;
          end else begin
            key_cnt_r <= key_cnt_r + KW'(1);
          end
        end
        ST_RIDE: begin
          key_level_r[key_cnt_r] <= key_goal_r[key_cnt_r] ?
                                    key_origin_r[key_cnt_r] + prod_r[30:15] :
                                    key_origin_r[key_cnt_r] - prod_r[30:15];
          if (key_last) begin
            state_r <= ST_OUT;
          end else begin
            key_cnt_r <= key_cnt_r + KW'(1);
            state_r   <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_stall == 1'b0) begin
            out_valid_r <= 1'b1;
            o_prog_r    <= program_r;
            o_prev_r    <= preview_r;
            o_alpha_r   <= alpha_r;
            o_style_r   <= style_r;
            o_soft_r    <= (softness_r > vstc_pkg::FULL) ? vstc_pkg::FULL : softness_r;
            o_fade_r    <= fade_r;
            o_active_r  <= active;
            o_levels_r  <= lvl_pack;
            o_on_r      <= on_pack;
            o_tie_r     <= tie_pack;
            o_src_r     <= src_pack;
            o_fol_r     <= fol_pack;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall              = state_r != ST_IDLE;
  assign out_valid             = out_valid_r;
  assign out_program_source    = o_prog_r;
  assign out_preview_source    = o_prev_r;
  assign out_mix_alpha         = o_alpha_r;
  assign out_style_out         = o_style_r;
  assign out_softness_out      = o_soft_r;
  assign out_fade_level        = o_fade_r;
  assign out_transition_active = o_active_r;
  assign out_keyer_levels      = o_levels_r;
  assign out_keyer_on_mask     = o_on_r;
  assign out_keyer_tie_mask    = o_tie_r;
  assign out_keyer_sources_out = o_src_r;
  assign out_keyer_follow_out  = o_fol_r;

  // auto and held bar never run together
  a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !(auto_run_r && tbar_held_r))
    else $error("auto and t-bar both running");

  // divider results only arrive while the sequencer waits for them
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_FADE_WAIT || state_r == ST_KEY_WAIT ||
                      state_r == ST_AUTO_WAIT))
    else $error("divider result outside a wait state");

  // fade level stays within full scale
  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    fade_r <= vstc_pkg::FULL)
    else $error("fade level above full");

  // a finished snapshot is never overwritten before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == ST_OUT) |=> state_r == ST_OUT)
    else $error("pending result overwritten");

endmodule

// File: rtl/core/vstc_div.sv
// shared iterative divider, one quotient bit per cycle
// depends on vstc_pkg
module vstc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vstc_pkg::div_req_t req,
  output vstc_pkg::div_res_t res
);

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [vstc_pkg::QB-1:0] quo_r;
  logic        ceil_r;
  logic        done_r;
  logic [15:0] res_q_r;

  logic [32:0] shl;
  logic [32:0] sub;
  logic        fits;
  logic [31:0] rem_nxt;
  logic [vstc_pkg::QB-1:0] quo_nxt;
  logic [15:0] fin_q;

  always_comb begin
    shl     = {rem_r, 1'b0};
    fits    = shl >= {1'b0, den_r};
    sub     = shl - {1'b0, den_r};
    rem_nxt = fits ? sub[31:0] : shl[31:0];
    quo_nxt = {quo_r[vstc_pkg::QB-2:0], fits};
    fin_q   = {1'b0, quo_nxt} + {15'd0, (ceil_r && (rem_nxt != 32'd0))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.num >= {1'b0, req.den}) begin
          // quotient reaches full scale, saturate
          res_q_r <= vstc_pkg::FULL;
          done_r  <= 1'b1;
        end else begin
          rem_r  <= req.num[31:0];
          den_r  <= req.den;
          ceil_r <= req.ceil;
          quo_r  <= '0;
          cnt_r  <= 4'(vstc_pkg::QB);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          res_q_r <= fin_q;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = res_q_r;

endmodule

// File: sim/video_switcher_transition_control_checker.sv
// checker of the transition controller: mirrors register writes and
// command transactions, predicts each tick snapshot and compares it
// depends on vstc_pkg
`timescale 1ns / 1ps

module video_switcher_transition_control_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic [31:0] in_now_tick,
  input  logic [7:0]  in_source,
  input  logic [15:0] in_tbar_position,
  input  logic [2:0]  in_keyer_index,
  input  logic        in_tie_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_program_source,
  input  logic [7:0]  out_preview_source,
  input  logic [15:0] out_mix_alpha,
  input  logic [2:0]  out_style_out,
  input  logic [15:0] out_softness_out,
  input  logic [15:0] out_fade_level,
  input  logic        out_transition_active,
  input  logic [63:0] out_keyer_levels,
  input  logic [3:0]  out_keyer_on_mask,
  input  logic [3:0]  out_keyer_tie_mask,
  input  logic [31:0] out_keyer_sources_out,
  input  logic [3:0]  out_keyer_follow_out,
  output int          pending,
  output int          errors
);

  localparam logic [3:0] CMD_TICK = 4'd0, CMD_PGM = 4'd1, CMD_PVW = 4'd2, CMD_CUT = 4'd3,
    CMD_AUTO = 4'd4, CMD_TBAR_BEGIN = 4'd5, CMD_TBAR_MOVE = 4'd6, CMD_FADE = 4'd7,
    CMD_KEY_TOGGLE = 4'd8, CMD_KEY_TIE = 4'd9;
  localparam logic [2:0] REG_TDUR = 3'd0, REG_STYLE = 3'd1, REG_SOFT = 3'd2, REG_FDUR = 3'd3,
    REG_KDUR = 3'd4, REG_KSRC = 3'd5, REG_FOLLOW = 3'd6;
  localparam int KC = vstc_pkg::KEYER_COUNT;

  typedef struct packed {
    logic [7:0]  pgm;
    logic [7:0]  pvw;
    logic [15:0] alpha;
    logic [2:0]  style;
    logic [15:0] softness;
    logic [15:0] fade;
    logic        active;
    logic [63:0] levels;
    logic [3:0]  on;
    logic [3:0]  tied;
    logic [31:0] srcs;
    logic [3:0]  follow;
  } snapshot_t;

  snapshot_t snapshot_q[$];

  // mirrored registers
  logic [31:0] t_dur, f_dur, k_src;
  logic [2:0]  style;
  logic [15:0] softness;
  logic [63:0] k_dur;
  logic [3:0]  follow;

  // mirrored state
  logic [7:0]  pgm_bus, pvw_bus;
  logic        auto_on, tbar_on, fade_goal, tick_seen;
  logic [31:0] auto_start, last_tick;
  logic [15:0] tbar_lvl, fade_lvl;
  logic [15:0] k_lvl [KC];
  logic [15:0] k_origin [KC];
  logic        k_goal [KC];
  logic        k_tied [KC];
  logic        k_ride [KC];

  assign pending = snapshot_q.size();

  // one ramp step toward the goal, ceil of elapsed over duration
  function automatic logic [15:0] ramp_level(logic [15:0] lvl, logic goal,
                                             logic [31:0] elapsed, logic [31:0] dur);
    logic [63:0] d, step;
    logic [15:0] target;
    if (elapsed == 0) return lvl;
    d = (dur == 0) ? 64'd1 : {32'd0, dur};
    step = (({32'd0, elapsed} << 15) + d - 1) / d;
    if (step > 64'd32768) step = 64'd32768;
    target = goal ? vstc_pkg::FULL : 16'd0;
    if (lvl < target) return ({48'd0, target - lvl} <= step) ? target : lvl + step[15:0];
    if (lvl > target) return ({48'd0, lvl - target} <= step) ? target : lvl - step[15:0];
    return lvl;
  endfunction

  task automatic end_transition();
    auto_on = 1'b0;
    tbar_on = 1'b0;
    tbar_lvl = '0;
  endtask

  task automatic land_transition();
    logic [7:0] t;
    logic was_active;
    t = pgm_bus;
    was_active = auto_on || tbar_on;
    pgm_bus = pvw_bus;
    pvw_bus = t;
    for (int k = 0; k < KC; k++) begin
      if (k_ride[k]) begin
        k_lvl[k] = k_goal[k] ? vstc_pkg::FULL : 16'd0;
        k_ride[k] = 1'b0;
      end else if (k_tied[k] && !was_active) begin
        k_goal[k] = !k_goal[k];
        k_lvl[k] = k_goal[k] ? vstc_pkg::FULL : 16'd0;
      end
    end
    end_transition();
  endtask

  task automatic abort_transition();
    for (int k = 0; k < KC; k++) begin
      if (k_ride[k]) begin
        k_ride[k] = 1'b0;
        k_goal[k] = k_origin[k] > vstc_pkg::HALF;
      end
    end
    end_transition();
  endtask

  task automatic arm_tied_keyers();
    for (int k = 0; k < KC; k++) begin
      if (k_tied[k]) begin
        k_ride[k] = 1'b1;
        k_origin[k] = k_lvl[k];
        k_goal[k] = !k_goal[k];
      end
    end
  endtask

  task automatic advance_switcher();
    logic [31:0] elapsed, dur;
    logic [63:0] n, prod;
    logic [15:0] alpha;
    snapshot_t s;
    alpha = '0;
    case (in_command)
      CMD_PGM: begin abort_transition(); pgm_bus = in_source; end
      CMD_PVW: begin abort_transition(); pvw_bus = in_source; end
      CMD_CUT: land_transition();
      CMD_AUTO: if (!(auto_on || tbar_on)) begin
        auto_on = 1'b1;
        auto_start = in_now_tick;
        arm_tied_keyers();
      end
      CMD_TBAR_BEGIN: if (!(auto_on || tbar_on)) begin
        tbar_on = 1'b1;
        arm_tied_keyers();
      end
      CMD_TBAR_MOVE: if (tbar_on) begin
        tbar_lvl = (in_tbar_position > vstc_pkg::FULL) ? vstc_pkg::FULL : in_tbar_position;
        if (tbar_lvl >= vstc_pkg::FULL) land_transition();
      end
      CMD_FADE: fade_goal = !fade_goal;
      CMD_KEY_TOGGLE: if (in_keyer_index < KC) begin
        k_goal[in_keyer_index] = !k_goal[in_keyer_index];
      end
      CMD_KEY_TIE: if (in_keyer_index < KC) begin
        k_tied[in_keyer_index] = in_tie_value;
        if (!in_tie_value) k_ride[in_keyer_index] = 1'b0;
      end
      CMD_TICK: begin
        elapsed = (tick_seen && in_now_tick > last_tick) ? in_now_tick - last_tick : 32'd0;
        fade_lvl = ramp_level(fade_lvl, fade_goal, elapsed, f_dur);
        for (int k = 0; k < KC; k++)
          if (!k_ride[k])
            k_lvl[k] = ramp_level(k_lvl[k], k_goal[k], elapsed, {16'd0, k_dur[16*k +: 16]});
        last_tick = in_now_tick;
        tick_seen = 1'b1;
        if (auto_on) begin
          dur = (t_dur == 0) ? 32'd1 : t_dur;
          if (in_now_tick >= auto_start) begin
            n = {32'd0, in_now_tick - auto_start} + 64'd1;
            if (n >= {32'd0, dur}) land_transition();
            else alpha = 16'((n << 15) / {32'd0, dur});
          end
        end else if (tbar_on) begin
          alpha = tbar_lvl;
        end
        if (auto_on || tbar_on) begin
          for (int k = 0; k < KC; k++) begin
            if (k_ride[k]) begin
              if (k_goal[k]) begin
                prod = ({48'd0, vstc_pkg::FULL - k_origin[k]} * alpha) >> 15;
                k_lvl[k] = k_origin[k] + prod[15:0];
              end else begin
                prod = ({48'd0, k_origin[k]} * alpha) >> 15;
                k_lvl[k] = k_origin[k] - prod[15:0];
              end
            end
          end
        end
        s = '0;
        for (int k = 0; k < KC; k++) begin
          s.levels[16*k +: 16] = k_lvl[k];
          s.on[k] = k_goal[k];
          s.tied[k] = k_tied[k];
          s.srcs[8*k +: 8] = k_src[8*k +: 8];
          s.follow[k] = follow[k];
        end
        s.pgm = pgm_bus;
        s.pvw = pvw_bus;
        s.alpha = alpha;
        s.style = style;
        s.softness = (softness > vstc_pkg::FULL) ? vstc_pkg::FULL : softness;
        s.fade = fade_lvl;
        s.active = auto_on || tbar_on;
        snapshot_q.push_back(s);
      end
      default: ;
    endcase
  endtask

  task automatic check_snapshot();
    snapshot_t e;
    if (snapshot_q.size() == 0) begin
      $error("output transaction with no snapshot expected");
      errors++;
      return;
    end
    e = snapshot_q.pop_front();
    if (out_program_source !== e.pgm) begin
      $error("program_source: expected %0d, got %0d", e.pgm, out_program_source); errors++;
    end
    if (out_preview_source !== e.pvw) begin
      $error("preview_source: expected %0d, got %0d", e.pvw, out_preview_source); errors++;
    end
    if (out_mix_alpha !== e.alpha) begin
      $error("mix_alpha: expected %0d, got %0d", e.alpha, out_mix_alpha); errors++;
    end
    if (out_style_out !== e.style) begin
      $error("style_out: expected %0d, got %0d", e.style, out_style_out); errors++;
    end
    if (out_softness_out !== e.softness) begin
      $error("softness_out: expected %0d, got %0d", e.softness, out_softness_out); errors++;
    end
    if (out_fade_level !== e.fade) begin
      $error("fade_level: expected %0d, got %0d", e.fade, out_fade_level); errors++;
    end
    if (out_transition_active !== e.active) begin
      $error("transition_active: expected %0d, got %0d", e.active, out_transition_active);
      errors++;
    end
    if (out_keyer_levels !== e.levels) begin
      $error("keyer_levels: expected %h, got %h", e.levels, out_keyer_levels); errors++;
    end
    if (out_keyer_on_mask !== e.on) begin
      $error("keyer_on_mask: expected %h, got %h", e.on, out_keyer_on_mask); errors++;
    end
    if (out_keyer_tie_mask !== e.tied) begin
      $error("keyer_tie_mask: expected %h, got %h", e.tied, out_keyer_tie_mask); errors++;
    end
    if (out_keyer_sources_out !== e.srcs) begin
      $error("keyer_sources_out: expected %h, got %h", e.srcs, out_keyer_sources_out); errors++;
    end
    if (out_keyer_follow_out !== e.follow) begin
      $error("keyer_follow_out: expected %h, got %h", e.follow, out_keyer_follow_out); errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      t_dur = 32'd30; f_dur = 32'd30; style = '0; softness = '0;
      k_dur = '0; k_src = '0; follow = '0;
      pgm_bus = '0; pvw_bus = '0; auto_on = 0; tbar_on = 0; fade_goal = 0; tick_seen = 0;
      auto_start = '0; last_tick = '0; tbar_lvl = '0; fade_lvl = '0;
      for (int k = 0; k < KC; k++) begin
        k_lvl[k] = '0; k_origin[k] = '0; k_goal[k] = 0; k_tied[k] = 0; k_ride[k] = 0;
      end
      snapshot_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TDUR:   t_dur = cfg_data[31:0];
          REG_STYLE:  style = cfg_data[2:0];
          REG_SOFT:   softness = cfg_data[15:0];
          REG_FDUR:   f_dur = cfg_data[31:0];
          REG_KDUR:   k_dur = cfg_data;
          REG_KSRC:   k_src = cfg_data[31:0];
          REG_FOLLOW: follow = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_snapshot();
      if (in_valid && !in_stall) advance_switcher();
    end
  end

endmodule

// File: sim/video_switcher_transition_control_tb.sv
// top of the transition controller testbench: clock, reset, stimulus, verdict
// depends on vstc_pkg, the controller and its checker
`timescale 1ns / 1ps

module video_switcher_transition_control_tb;

  localparam logic [3:0] CMD_TICK = 4'd0, CMD_PGM = 4'd1, CMD_PVW = 4'd2, CMD_CUT = 4'd3,
    CMD_AUTO = 4'd4, CMD_TBAR_BEGIN = 4'd5, CMD_TBAR_MOVE = 4'd6, CMD_FADE = 4'd7,
    CMD_KEY_TOGGLE = 4'd8, CMD_KEY_TIE = 4'd9, CMD_UNKNOWN_LO = 4'd10,
    CMD_UNKNOWN_HI = 4'd15;
  localparam logic [2:0] REG_TDUR = 3'd0, REG_STYLE = 3'd1, REG_SOFT = 3'd2, REG_FDUR = 3'd3,
    REG_KDUR = 3'd4, REG_KSRC = 3'd5, REG_FOLLOW = 3'd6, REG_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 150;        // margin for the longest tick to finish
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 80;

  logic        clk = 0, rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 0, in_stall;
  logic [3:0]  in_command = '0;
  logic [31:0] in_now_tick = '0;
  logic [7:0]  in_source = '0;
  logic [15:0] in_tbar_position = '0;
  logic [2:0]  in_keyer_index = '0;
  logic        in_tie_value = 0;
  logic        out_valid, out_stall = 0;
  logic [7:0]  out_program_source, out_preview_source;
  logic [15:0] out_mix_alpha, out_softness_out, out_fade_level;
  logic [2:0]  out_style_out;
  logic        out_transition_active;
  logic [63:0] out_keyer_levels;
  logic [3:0]  out_keyer_on_mask, out_keyer_tie_mask, out_keyer_follow_out;
  logic [31:0] out_keyer_sources_out;
  int          pending, errors, cycles = 0;
  bit          calm = 0;        // no idling on either side while set
  logic [31:0] show_clock = '0; // running tick time of the show

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  video_switcher_transition_control DUT (.*);
  video_switcher_transition_control_checker checker_i (.*);

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side stalls at random, except in the calm stretch
  always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);

  // one command transaction; random idle cycles ahead of it
  task automatic send(logic [3:0] cmd, logic [31:0] now, logic [7:0] src,
                      logic [15:0] pos, logic [2:0] ki, logic tie);
    while (!calm && $urandom_range(99) < 19) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_now_tick <= now;
    in_source <= src;
    in_tbar_position <= pos;
    in_keyer_index <= ki;
    in_tie_value <= tie;
    do @(posedge clk); while (in_stall);
  endtask

  // command with random filler in the fields it does not use
  task automatic send_cmd(logic [3:0] cmd, logic [31:0] now);
    send(cmd, now, 8'($urandom), 16'($urandom), 3'($urandom), 1'($urandom));
  endtask

  // wait until every snapshot is out and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed show traffic: ticks, transitions, keys, fades
  task automatic random_item();
    int r;
    logic [15:0] pos;
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(19))
        0:       show_clock = $urandom;                        // jump anywhere
        1:       show_clock = show_clock - $urandom_range(3);  // backwards
        default: show_clock = show_clock + $urandom_range(4);
      endcase
      send_cmd(CMD_TICK, show_clock);
    end else if (r < 48) send_cmd(CMD_AUTO, show_clock - $urandom_range(1));
    else if (r < 55) send_cmd(CMD_TBAR_BEGIN, $urandom);
    else if (r < 68) begin
      case ($urandom_range(19))
        0, 1, 2: pos = vstc_pkg::FULL;
        3:       pos = 16'($urandom);
        default: pos = 16'($urandom_range(32768));
      endcase
      send(CMD_TBAR_MOVE, $urandom, 8'($urandom), pos, 3'($urandom), 1'($urandom));
    end
    else if (r < 72) send_cmd(CMD_PGM, $urandom);
    else if (r < 76) send_cmd(CMD_PVW, $urandom);
    else if (r < 80) send_cmd(CMD_CUT, $urandom);
    else if (r < 85) send_cmd(CMD_FADE, $urandom);
    else if (r < 91) send_cmd(CMD_KEY_TOGGLE, $urandom);
    else if (r < 97) send_cmd(CMD_KEY_TIE, $urandom);
    else send_cmd(4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)), $urandom);
  endtask

  initial begin
    static logic [31:0] t_dur [PHASES] = '{32'd0, 32'd1, 32'd12, 32'hFFFF_FFFF, 32'd5};
    static logic [31:0] f_dur [PHASES] = '{32'd1, 32'd0, 32'd40, 32'hFFFF_FFFF, 32'd7};
    static logic [15:0] soft_set [PHASES] = '{16'hFFFF, 16'd0, 16'd32768, 16'd32769,
                                              16'd16384};
    static logic [63:0] k_dur [PHASES] = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                                           64'h0003_0001_0008_0010, 64'h0002_0000_0005_0001,
                                           64'h0000_0006_0001_0004};
    static logic [2:0]  style [PHASES] = '{3'd7, 3'd0, 3'd3, 3'd5, 3'd1};
    static logic [3:0]  fol   [PHASES] = '{4'hF, 4'h0, 4'h5, 4'hA, 4'h3};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, field extremes, every command, ignored cases
    send_cmd(CMD_TICK, 32'd0);
    send(CMD_PGM, '0, 8'd255, '0, '0, 0);
    send(CMD_PVW, '1, 8'd0, '1, '1, 1);
    send(CMD_KEY_TIE, '0, '0, '0, 3'd0, 1'b1);
    send(CMD_KEY_TIE, '0, '0, '0, 3'd3, 1'b1);
    send(CMD_KEY_TIE, '0, '0, '0, 3'd7, 1'b1);       // absent keyer
    send(CMD_KEY_TOGGLE, '0, '0, '0, 3'd4, 1'b0);    // absent keyer
    send(CMD_TBAR_MOVE, '0, '0, 16'd16384, '0, 0);   // free t-bar
    send(CMD_CUT, '0, '0, '0, '0, 0);                // cut with tied keyers
    send(CMD_AUTO, 32'd10, '0, '0, '0, 0);
    send(CMD_TBAR_BEGIN, '0, '0, '0, '0, 0);         // busy start
    send(CMD_TICK, 32'd5, '0, '0, '0, 0);            // before auto start
    send(CMD_TICK, 32'd20, '0, '0, '0, 0);
    send(CMD_TICK, 32'd60, '0, '0, '0, 0);           // lands
    send(CMD_TBAR_BEGIN, '0, '0, '0, '0, 0);
    send(CMD_TBAR_MOVE, '0, '0, 16'd12000, '0, 0);
    send(CMD_TICK, 32'd61, '0, '0, '0, 0);
    send(CMD_PGM, '0, 8'd7, '0, '0, 0);              // cancel while riding
    send(CMD_FADE, '0, '0, '0, '0, 0);
    send(CMD_KEY_TOGGLE, '0, '0, '0, 3'd1, 0);
    send(CMD_TICK, 32'hFFFF_FFFF, '0, '0, '0, 0);
    send(CMD_TBAR_BEGIN, '0, '0, '0, '0, 0);
    send(CMD_TBAR_MOVE, '0, '0, 16'hFFFF, '0, 0);    // over full, lands
    send(CMD_UNKNOWN_HI, '1, '1, '1, '1, 1);
    send(CMD_TICK, 32'd3, '0, '0, '0, 0);            // backwards
    show_clock = 32'd3;

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_TDUR, {32'($urandom), t_dur[p]});
      write_reg(REG_STYLE, {61'($urandom), style[p]});
      write_reg(REG_SOFT, {48'($urandom), soft_set[p]});
      write_reg(REG_FDUR, {32'($urandom), f_dur[p]});
      write_reg(REG_KDUR, k_dur[p]);
      write_reg(REG_KSRC, {32'($urandom), (p == 1) ? 32'hFFFF_FFFF : 32'($urandom)});
      write_reg(REG_FOLLOW, {60'($urandom), fol[p]});
      write_reg(REG_NONE, {$urandom, $urandom});
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    calm = 0;
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
